// ----- hw/rtl/arp_pkg.sv -----
// Shared types, constants and codes for the ARP resolver.
package arp_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int PENDING_IPS = 8;
  localparam int QUEUE_PER_IP = 8;
  localparam int CW = $clog2(CACHE_ENTRIES);
  localparam int PW = $clog2(PENDING_IPS);
  localparam int QW = $clog2(QUEUE_PER_IP);
  localparam int CNTW = $clog2(QUEUE_PER_IP + 1);
  localparam int HW = $clog2(PENDING_IPS * QUEUE_PER_IP);
  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] ACT_SEND = 2'd0;
  localparam logic [1:0] ACT_RECV = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;
  localparam logic [1:0] FT_IPV4 = 2'd0;
  localparam logic [1:0] FT_ARP = 2'd1;
  localparam logic [1:0] OP_REQ = 2'd0;
  localparam logic [1:0] KIND_IPV4 = 2'd0;
  localparam logic [1:0] KIND_ARPREQ = 2'd1;
  localparam logic [1:0] KIND_ARPREP = 2'd2;
  localparam logic [1:0] KIND_UP = 2'd3;
  localparam logic [1:0] REG_MY_MAC = 2'd0;
  localparam logic [1:0] REG_MY_IP = 2'd1;
  localparam logic [1:0] REG_ENTRY_TTL = 2'd2;
  localparam logic [1:0] REG_REPLY_TTL = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] hop_ip;
    logic [15:0] dgram_handle;
    logic [47:0] frame_dst_mac;
    logic [1:0]  eth_type;
    logic        parse_ok;
    logic [1:0]  arp_opcode;
    logic [31:0] arp_sender_ip;
    logic [47:0] arp_sender_mac;
    logic [31:0] arp_target_ip;
    logic [31:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] dst_mac;
    logic [15:0] out_handle;
    logic [31:0] target_ip;
    logic [47:0] target_mac;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TICK, ST_DECIDE, ST_EMIT, ST_FLUSH_RD, ST_FLUSH
  } state_t;

  // Per-cell command broadcast along a cell row (cache or pending).
  typedef struct packed {
    logic        tick;
    logic [31:0] elapsed;
    logic [31:0] ttl;
    logic        wr;
    logic [31:0] wr_ip;
    logic [47:0] wr_mac;
  } cell_cmd_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ----- hw/rtl/arp_resolver_with_pending_queue.sv -----
// Top level of the ARP resolver with per-address pending queue.
// Usage:
//  - Input channel (in_valid/in_stall/in_data) carries one transaction per
//    send, received frame or time tick. Output channel (out_valid/out_stall/
//    out_data) carries result transactions; the final one of an input has
//    last set. Inputs that cause nothing produce no transaction.
//  - Configuration: cfg_we/cfg_index/cfg_data write my_mac, my_ip and the two
//    TTLs; write only while idle.
//  - One transaction at a time. A send or a frame is matched against a row
//    of 16 cache cells and 8 pending cells in the cycle after acceptance, and
//    its first result is registered and then loaded into the output register
//    in the emit state, which waits while the output is stalled; the input
//    stays busy until the sequencer is back in idle. A flush reads the handle
//    RAM and then emits, once for each queued handle, up to 8 of them.
//    A tick ages every cell in parallel.
//  - Oldest-entry replacement reduces the cache cell ages in a compare tree
//    within the decide cycle.
//  - Reset clears all valid bits and counts; no clearing pass is needed.
//  - A stall on the output holds the result register; the sequencer waits.
module arp_resolver_with_pending_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  arp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output arp_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [47:0]         cfg_data
);
  localparam int C = arp_pkg::CACHE_ENTRIES;
  localparam int P = arp_pkg::PENDING_IPS;

  // configuration
  logic [47:0] my_mac;
  logic [31:0] my_ip, entry_ttl, reply_ttl;
  always_ff @(posedge clk) begin
    if (rst) begin
      my_mac <= '0;
      my_ip <= '0;
      entry_ttl <= 32'd30000;
      reply_ttl <= 32'd5000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        arp_pkg::REG_MY_MAC:    my_mac <= cfg_data;
        arp_pkg::REG_MY_IP:     my_ip <= cfg_data[31:0];
        arp_pkg::REG_ENTRY_TTL: entry_ttl <= cfg_data[31:0];
        arp_pkg::REG_REPLY_TTL: reply_ttl <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  arp_pkg::state_t state, state_next;
  arp_pkg::in_item_t item;

  // cache row
  arp_pkg::cell_cmd_t ccmd, pcmd;
  logic [C-1:0] c_hit, c_vld, c_sel;
  logic [47:0]  c_mac [C];
  logic [31:0]  c_age [C];
  logic [31:0]  c_key;
  // pending row
  logic [P-1:0] p_hit, p_vld, p_sel, p_clr;
  logic [47:0]  p_macu [P];
  logic [31:0]  p_age [P];
  logic [arp_pkg::CNTW-1:0] pcount [P];

  for (genvar g = 0; g < C; g++) begin : g_cache
    arp_cell u_cell (
      .clk, .rst, .cmd(ccmd), .sel(c_sel[g]), .clr(1'b0), .key(c_key),
      .hit(c_hit[g]), .vld(c_vld[g]), .mac_q(c_mac[g]), .age_q(c_age[g])
    );
  end
  for (genvar g = 0; g < P; g++) begin : g_pend
    arp_cell u_cell (
      .clk, .rst, .cmd(pcmd), .sel(p_sel[g]), .clr(p_clr[g]), .key(c_key),
      .hit(p_hit[g]), .vld(p_vld[g]), .mac_q(p_macu[g]), .age_q(p_age[g])
    );
  end

  // key: hop for send, sender ip for ARP
  assign c_key = (item.action == arp_pkg::ACT_SEND) ? item.hop_ip : item.arp_sender_ip;

  // decode of the current item, registered in ST_DECIDE
  logic c_any, p_any, p_free_any;
  logic [arp_pkg::CW-1:0] c_hidx, c_fidx, c_oidx, c_slot;
  logic [arp_pkg::PW-1:0] p_hidx, p_fidx;
  logic c_free_any;
  // oldest-entry tree: the lower index wins a tie
  logic [31:0]            o_age [C];
  logic [arp_pkg::CW-1:0] o_idx [C];
  always_comb begin
    c_any = 1'b0; c_hidx = '0; c_free_any = 1'b0; c_fidx = '0;
    for (int i = C - 1; i >= 0; i--) begin
      if (c_hit[i]) begin c_any = 1'b1; c_hidx = arp_pkg::CW'(i); end
      if (!c_vld[i]) begin c_free_any = 1'b1; c_fidx = arp_pkg::CW'(i); end
    end
    for (int i = 0; i < C; i++) begin
      o_age[i] = c_age[i];
      o_idx[i] = arp_pkg::CW'(i);
    end
    for (int s = 1; s < C; s = s * 2) begin
      for (int i = 0; i + s < C; i = i + 2 * s) begin
        if (o_age[i + s] > o_age[i]) begin
          o_age[i] = o_age[i + s];
          o_idx[i] = o_idx[i + s];
        end
      end
    end
    c_oidx = o_idx[0];
    c_slot = c_any ? c_hidx : (c_free_any ? c_fidx : c_oidx);
    p_any = 1'b0; p_hidx = '0; p_free_any = 1'b0; p_fidx = '0;
    for (int i = P - 1; i >= 0; i--) begin
      if (p_hit[i]) begin p_any = 1'b1; p_hidx = arp_pkg::PW'(i); end
      if (!p_vld[i]) begin p_free_any = 1'b1; p_fidx = arp_pkg::PW'(i); end
    end
  end

  logic addr_ok, is_arp, is_req;
  assign addr_ok = (item.frame_dst_mac == my_mac) ||
                   (item.frame_dst_mac == arp_pkg::BCAST_MAC);
  assign is_arp = (item.action == arp_pkg::ACT_RECV) && addr_ok &&
                  (item.eth_type == arp_pkg::FT_ARP) && item.parse_ok;
  assign is_req = is_arp && (item.arp_opcode == arp_pkg::OP_REQ) &&
                  (item.arp_target_ip == my_ip);

  // handle RAM
  logic hr_we;
  logic [arp_pkg::HW-1:0] hr_waddr, hr_raddr;
  logic [15:0] hr_rdata;
  arp_ram #(.WIDTH(16), .DEPTH(P * arp_pkg::QUEUE_PER_IP)) u_handles (
    .clk, .we(hr_we), .waddr(hr_waddr), .wdata(item.dgram_handle),
    .raddr(hr_raddr), .rdata(hr_rdata)
  );

  // flush bookkeeping
  logic [arp_pkg::PW-1:0]   fl_slot;
  logic [arp_pkg::CNTW-1:0] fl_cnt, fl_idx;
  logic fl_active;

  // single pending result and output register
  logic res_valid;
  arp_pkg::out_item_t res;
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  logic dec_en;
  assign dec_en = (state == arp_pkg::ST_DECIDE);

  // cell commands
  always_comb begin
    ccmd = '0;
    pcmd = '0;
    ccmd.tick = (state == arp_pkg::ST_TICK);
    pcmd.tick = ccmd.tick;
    ccmd.elapsed = item.elapsed_ms;
    pcmd.elapsed = item.elapsed_ms;
    ccmd.ttl = entry_ttl;
    pcmd.ttl = reply_ttl;
    ccmd.wr = dec_en && is_arp;
    ccmd.wr_ip = item.arp_sender_ip;
    ccmd.wr_mac = item.arp_sender_mac;
    pcmd.wr = dec_en && (item.action == arp_pkg::ACT_SEND) && !c_any && !p_any &&
              p_free_any;
    pcmd.wr_ip = item.hop_ip;
    pcmd.wr_mac = '0;
    c_sel = '0;
    c_sel[c_slot] = 1'b1;
    p_sel = '0;
    p_sel[p_fidx] = 1'b1;
  end
  assign p_clr = '0;

  // pending counts live beside the cells; cleared on expiry or flush
  logic send_q;
  assign send_q = dec_en && (item.action == arp_pkg::ACT_SEND) && !c_any && p_any &&
                  (pcount[p_hidx] < arp_pkg::CNTW'(arp_pkg::QUEUE_PER_IP));
  always_ff @(posedge clk) begin
    for (int i = 0; i < P; i++) begin
      if (rst) begin
        pcount[i] <= '0;
      end else if (pcmd.wr && p_sel[i]) begin
        pcount[i] <= arp_pkg::CNTW'(1);
      end else if (send_q && p_hidx == arp_pkg::PW'(i)) begin
        pcount[i] <= pcount[i] + 1'b1;
      end else if (dec_en && is_arp && p_any && p_hidx == arp_pkg::PW'(i)) begin
        pcount[i] <= '0;
      end else if (pcmd.tick && p_vld[i] &&
                   arp_pkg::sat_add(p_age[i], item.elapsed_ms) >= reply_ttl) begin
        pcount[i] <= '0;
      end
    end
  end

  always_comb begin
    hr_we = 1'b0;
    hr_waddr = '0;
    if (pcmd.wr) begin
      hr_we = 1'b1;
      hr_waddr = arp_pkg::HW'(p_fidx * arp_pkg::QUEUE_PER_IP);
    end else if (send_q) begin
      hr_we = 1'b1;
      hr_waddr = arp_pkg::HW'(p_hidx * arp_pkg::QUEUE_PER_IP +
                 int'(pcount[p_hidx]));
    end
    hr_raddr = arp_pkg::HW'(fl_slot * arp_pkg::QUEUE_PER_IP + int'(fl_idx[arp_pkg::QW-1:0]));
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= arp_pkg::ST_IDLE;
    else state <= state_next;
  end

  logic flush_more;
  assign flush_more = (fl_idx + 1'b1) < fl_cnt;

  always_comb begin
    state_next = state;
    unique case (state)
      arp_pkg::ST_IDLE:
        if (in_valid) begin
          state_next = (in_data.action == arp_pkg::ACT_TICK) ? arp_pkg::ST_TICK
                                                              : arp_pkg::ST_DECIDE;
        end
      arp_pkg::ST_TICK: state_next = arp_pkg::ST_IDLE;
      arp_pkg::ST_DECIDE: state_next = arp_pkg::ST_EMIT;
      arp_pkg::ST_EMIT:
        if (!res_valid) state_next = fl_active ? arp_pkg::ST_FLUSH_RD : arp_pkg::ST_IDLE;
        else if (out_free) begin
          state_next = fl_active ? arp_pkg::ST_FLUSH_RD : arp_pkg::ST_IDLE;
        end
      arp_pkg::ST_FLUSH_RD: state_next = arp_pkg::ST_FLUSH;
      arp_pkg::ST_FLUSH:
        if (out_free) state_next = flush_more ? arp_pkg::ST_FLUSH_RD : arp_pkg::ST_IDLE;
      default: state_next = arp_pkg::ST_IDLE;
    endcase
  end

  // hold off input during reset and while a transaction is in progress
  assign in_stall = rst || (state != arp_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (state == arp_pkg::ST_IDLE && in_valid) item <= in_data;
  end

  // decide: build first result and flush plan
  arp_pkg::out_item_t res_next;
  logic res_valid_next, fl_active_next, flush_hit;
  assign flush_hit = p_any && (pcount[p_hidx] != '0);

  always_comb begin
    res_next = '0;
    res_valid_next = 1'b0;
    fl_active_next = 1'b0;
    if (item.action == arp_pkg::ACT_SEND) begin
      if (c_any) begin
        res_valid_next = 1'b1;
        res_next.kind = arp_pkg::KIND_IPV4;
        res_next.dst_mac = c_mac[c_hidx];
        res_next.out_handle = item.dgram_handle;
        res_next.last = 1'b1;
      end else if (!p_any && p_free_any) begin
        res_valid_next = 1'b1;
        res_next.kind = arp_pkg::KIND_ARPREQ;
        res_next.dst_mac = arp_pkg::BCAST_MAC;
        res_next.target_ip = item.hop_ip;
        res_next.last = 1'b1;
      end
    end else if (item.action == arp_pkg::ACT_RECV && addr_ok) begin
      if (item.eth_type == arp_pkg::FT_IPV4 && item.parse_ok) begin
        res_valid_next = 1'b1;
        res_next.kind = arp_pkg::KIND_UP;
        res_next.out_handle = item.dgram_handle;
        res_next.last = 1'b1;
      end else if (is_arp) begin
        fl_active_next = flush_hit;
        if (is_req) begin
          res_valid_next = 1'b1;
          res_next.kind = arp_pkg::KIND_ARPREP;
          res_next.dst_mac = item.arp_sender_mac;
          res_next.target_ip = item.arp_sender_ip;
          res_next.target_mac = item.arp_sender_mac;
          res_next.last = !flush_hit;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      fl_active <= 1'b0;
    end else if (dec_en) begin
      res_valid <= res_valid_next;
      fl_active <= fl_active_next;
      res <= res_next;
      fl_slot <= p_hidx;
      fl_cnt <= pcount[p_hidx];
      fl_idx <= '0;
    end else if (state == arp_pkg::ST_FLUSH && out_free) begin
      fl_idx <= fl_idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      if (state == arp_pkg::ST_EMIT && res_valid) begin
        out_valid <= 1'b1;
        out_data <= res;
      end else if (state == arp_pkg::ST_FLUSH) begin
        out_valid <= 1'b1;
        out_data.kind <= arp_pkg::KIND_IPV4;
        out_data.dst_mac <= item.arp_sender_mac;
        out_data.out_handle <= hr_rdata;
        out_data.target_ip <= '0;
        out_data.target_mac <= '0;
        out_data.last <= !flush_more;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// ----- hw/rtl/arp_ram.sv -----
// Generic simple dual-port RAM (one write port, one read port) with registered read.
module arp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/arp_cell.sv -----
// One table cell: valid, ip, mac, saturating age; compares its ip against a key.
module arp_cell (
  input  logic              clk,
  input  logic              rst,
  input  arp_pkg::cell_cmd_t cmd,
  input  logic              sel,
  input  logic              clr,
  input  logic [31:0]       key,
  output logic              hit,
  output logic              vld,
  output logic [47:0]       mac_q,
  output logic [31:0]       age_q
);
  logic        valid;
  logic [31:0] ip;
  logic [47:0] mac;
  logic [31:0] age;
  logic [31:0] age_next;

  assign age_next = arp_pkg::sat_add(age, cmd.elapsed);
  assign hit = valid && (ip == key);
  assign vld = valid;
  assign mac_q = mac;
  assign age_q = age;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.wr && sel) begin
      valid <= 1'b1;
    end else if (clr) begin
      valid <= 1'b0;
    end else if (cmd.tick && valid && age_next >= cmd.ttl) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && sel) begin
      ip  <= cmd.wr_ip;
      mac <= cmd.wr_mac;
      age <= '0;
    end else if (cmd.tick && valid) begin
      age <= age_next;
    end
  end
endmodule

// ----- sim/arp_resolver_checker.sv -----
`timescale 1ns / 1ps
// Checker for the ARP resolver: mirrors the address cache and pending queues, compares results.
module arp_resolver_checker
  import arp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [47:0] cfg_data,
  output int         errors,
  output int         pending_results,
  output int         results_seen
);

  logic [47:0] mac_reg;
  logic [31:0] ip_reg, entry_ttl, reply_ttl;
  logic        c_vld [CACHE_ENTRIES];
  logic [31:0] c_ip  [CACHE_ENTRIES];
  logic [47:0] c_mac [CACHE_ENTRIES];
  logic [31:0] c_age [CACHE_ENTRIES];
  logic        p_vld [PENDING_IPS];
  logic [31:0] p_ip  [PENDING_IPS];
  logic [31:0] p_age [PENDING_IPS];
  int          p_cnt [PENDING_IPS];
  logic [15:0] p_hdl [PENDING_IPS][QUEUE_PER_IP];
  out_item_t   frames_due[$];

  assign pending_results = frames_due.size();

  function automatic logic [31:0] age_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int cache_lookup(logic [31:0] ip);
    for (int i = 0; i < CACHE_ENTRIES; i++) if (c_vld[i] && c_ip[i] == ip) return i;
    return -1;
  endfunction

  function automatic int queue_lookup(logic [31:0] ip);
    for (int i = 0; i < PENDING_IPS; i++) if (p_vld[i] && p_ip[i] == ip) return i;
    return -1;
  endfunction

  task automatic push_frame(logic [1:0] k, logic [47:0] dm, logic [15:0] h,
                            logic [31:0] tip, logic [47:0] tm);
    out_item_t r;
    r = '{kind: k, dst_mac: dm, out_handle: h, target_ip: tip, target_mac: tm, last: 1'b0};
    frames_due.push_back(r);
  endtask

  task automatic learn_binding(logic [31:0] ip, logic [47:0] mac);
    int slot;
    slot = cache_lookup(ip);
    if (slot < 0)
      for (int i = 0; i < CACHE_ENTRIES && slot < 0; i++) if (!c_vld[i]) slot = i;
    if (slot < 0) begin
      slot = 0;
      for (int i = 1; i < CACHE_ENTRIES; i++) if (c_age[i] > c_age[slot]) slot = i;
    end
    c_vld[slot] = 1'b1;
    c_ip[slot] = ip;
    c_mac[slot] = mac;
    c_age[slot] = '0;
  endtask

  // Apply one transaction to the mirror and queue the frames it produces.
  task automatic resolve_item(in_item_t t);
    int base, ci, pi;
    base = frames_due.size();
    if (t.action == ACT_SEND) begin
      ci = cache_lookup(t.hop_ip);
      if (ci >= 0) push_frame(KIND_IPV4, c_mac[ci], t.dgram_handle, '0, '0);
      else begin
        pi = queue_lookup(t.hop_ip);
        if (pi >= 0) begin
          if (p_cnt[pi] < QUEUE_PER_IP) begin
            p_hdl[pi][p_cnt[pi]] = t.dgram_handle;
            p_cnt[pi]++;
          end
        end else begin
          for (int i = 0; i < PENDING_IPS && pi < 0; i++) if (!p_vld[i]) pi = i;
          if (pi >= 0) begin
            p_vld[pi] = 1'b1;
            p_ip[pi] = t.hop_ip;
            p_age[pi] = '0;
            p_cnt[pi] = 1;
            p_hdl[pi][0] = t.dgram_handle;
            push_frame(KIND_ARPREQ, BCAST_MAC, '0, t.hop_ip, '0);
          end
        end
      end
    end else if (t.action == ACT_RECV) begin
      if (t.frame_dst_mac == mac_reg || t.frame_dst_mac == BCAST_MAC) begin
        if (t.eth_type == FT_IPV4) begin
          if (t.parse_ok) push_frame(KIND_UP, '0, t.dgram_handle, '0, '0);
        end else if (t.eth_type == FT_ARP && t.parse_ok) begin
          learn_binding(t.arp_sender_ip, t.arp_sender_mac);
          if (t.arp_opcode == OP_REQ && t.arp_target_ip == ip_reg)
            push_frame(KIND_ARPREP, t.arp_sender_mac, '0, t.arp_sender_ip, t.arp_sender_mac);
          pi = queue_lookup(t.arp_sender_ip);
          if (pi >= 0) begin
            for (int k = 0; k < p_cnt[pi]; k++)
              push_frame(KIND_IPV4, t.arp_sender_mac, p_hdl[pi][k], '0, '0);
            p_cnt[pi] = 0;
          end
        end
      end
    end else if (t.action == ACT_TICK) begin
      for (int i = 0; i < CACHE_ENTRIES; i++) if (c_vld[i]) begin
        c_age[i] = age_add(c_age[i], t.elapsed_ms);
        if (c_age[i] >= entry_ttl) c_vld[i] = 1'b0;
      end
      for (int i = 0; i < PENDING_IPS; i++) if (p_vld[i]) begin
        p_age[i] = age_add(p_age[i], t.elapsed_ms);
        if (p_age[i] >= reply_ttl) begin
          p_vld[i] = 1'b0;
          p_cnt[i] = 0;
        end
      end
    end
    if (frames_due.size() > base) frames_due[frames_due.size() - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ERROR %s: got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      mac_reg <= '0; ip_reg <= '0; entry_ttl <= 32'd30000; reply_ttl <= 32'd5000;
      for (int i = 0; i < CACHE_ENTRIES; i++) c_vld[i] = 1'b0;
      for (int i = 0; i < PENDING_IPS; i++) begin
        p_vld[i] = 1'b0;
        p_cnt[i] = 0;
      end
      frames_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MY_MAC:    mac_reg <= cfg_data;
          REG_MY_IP:     ip_reg <= cfg_data[31:0];
          REG_ENTRY_TTL: entry_ttl <= cfg_data[31:0];
          REG_REPLY_TTL: reply_ttl <= cfg_data[31:0];
          default: ;
        endcase
      end
      // Compare the result before predicting the same edge's input; order is causal anyway.
      if (out_valid && !out_stall) begin
        results_seen++;
        if (frames_due.size() == 0)
          report_mismatch("unexpected result", out_data.kind, 0);
        else begin
          e = frames_due.pop_front();
          if (out_data.kind !== e.kind) report_mismatch("kind", out_data.kind, e.kind);
          if (out_data.dst_mac !== e.dst_mac)
            report_mismatch("dst_mac", out_data.dst_mac, e.dst_mac);
          if (out_data.out_handle !== e.out_handle)
            report_mismatch("out_handle", out_data.out_handle, e.out_handle);
          if (out_data.target_ip !== e.target_ip)
            report_mismatch("target_ip", out_data.target_ip, e.target_ip);
          if (out_data.target_mac !== e.target_mac)
            report_mismatch("target_mac", out_data.target_mac, e.target_mac);
          if (out_data.last !== e.last) report_mismatch("last", out_data.last, e.last);
        end
      end
      if (in_valid && !in_stall) resolve_item(in_data);
    end
  end

  initial begin
    errors = 0;
    results_seen = 0;
  end

endmodule

// ----- sim/tb_arp_resolver_with_pending_queue.sv -----
`timescale 1ns / 1ps
// Testbench top for the ARP resolver: stimulus, configuration phases and verdict.
module tb_arp_resolver_with_pending_queue;
  import arp_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_MY_MAC;
  logic [47:0] cfg_data = '0;
  int         errors, results_due, results_seen;
  int         sent_items;
  bit         calm;        // no idling on either side near the end
  bit         hold_off;    // long receiver hold-off to fill the block up

  // Small address pools so sends, replies and flushes hit the same IPs often.
  logic [31:0] ip_pool [12];
  logic [47:0] mac_pool [12];
  logic [47:0] host_mac;
  logic [31:0] host_ip;

  always #2 clk = ~clk;

  arp_resolver_with_pending_queue DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  arp_resolver_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending_results(results_due), .results_seen(results_seen)
  );

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        out_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
    end
  end

  // Offer one transaction and hold it until accepted, sometimes with a random gap first.
  task automatic offer(in_item_t t);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t mk_send(logic [31:0] ip, logic [15:0] h);
    in_item_t t;
    t = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    t.action = ACT_SEND;
    t.hop_ip = ip;
    t.dgram_handle = h;
    return t;
  endfunction

  function automatic in_item_t mk_arp(logic [47:0] dst, logic [1:0] op, logic [31:0] sip,
                                      logic [47:0] smac, logic [31:0] tip, logic ok);
    in_item_t t;
    t = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    t.action = ACT_RECV;
    t.frame_dst_mac = dst;
    t.eth_type = FT_ARP;
    t.parse_ok = ok;
    t.arp_opcode = op;
    t.arp_sender_ip = sip;
    t.arp_sender_mac = smac;
    t.arp_target_ip = tip;
    return t;
  endfunction

  function automatic in_item_t mk_ipv4(logic [47:0] dst, logic [15:0] h, logic ok);
    in_item_t t;
    t = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    t.action = ACT_RECV;
    t.frame_dst_mac = dst;
    t.eth_type = FT_IPV4;
    t.dgram_handle = h;
    t.parse_ok = ok;
    return t;
  endfunction

  function automatic in_item_t mk_tick(logic [31:0] ms);
    in_item_t t;
    t = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    t.action = ACT_TICK;
    t.elapsed_ms = ms;
    return t;
  endfunction

  function automatic logic [47:0] pick_dst();
    case ($urandom_range(0, 5))
      0:       return 48'({$urandom, $urandom});
      1, 2:    return BCAST_MAC;
      default: return host_mac;
    endcase
  endfunction

  // Mostly well-formed traffic over a small address pool, some noise.
  function automatic in_item_t random_item();
    in_item_t t;
    int a;
    a = $urandom_range(0, 19);
    if (a < 8) t = mk_send(ip_pool[$urandom_range(0, 11)], 16'($urandom));
    else if (a < 14)
      t = mk_arp(pick_dst(), 2'($urandom_range(0, 3)), ip_pool[$urandom_range(0, 11)],
                 $urandom_range(0, 1) ? mac_pool[$urandom_range(0, 11)]
                                      : 48'({$urandom, $urandom}),
                 $urandom_range(0, 2) == 0 ? $urandom : host_ip,
                 $urandom_range(0, 7) != 0);
    else if (a < 16) t = mk_ipv4(pick_dst(), 16'($urandom), $urandom_range(0, 3) != 0);
    else if (a < 18) t = mk_tick($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000));
    else begin
      // noise: any action and frame type, including the unused codes
      t = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      t.action = 2'($urandom_range(0, 3));
      t.hop_ip = ip_pool[$urandom_range(0, 11)];
      if ($urandom_range(0, 1)) t.frame_dst_mac = host_mac;
    end
    return t;
  endfunction

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sent_items = 0;
    calm = 1'b0;
    hold_off = 1'b0;
    for (int i = 0; i < 12; i++) begin
      ip_pool[i] = $urandom;
      mac_pool[i] = 48'({$urandom, $urandom});
    end
    host_mac = 48'h0;
    host_ip = 32'h0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, with reset configuration (our MAC and IP are zero).
    offer(mk_send(32'h0, 16'h0));                            // miss, broadcast request
    offer(mk_send(32'h0, 16'hFFFF));                         // queue, no new request
    offer(mk_arp(48'h0, OP_REQ, 32'h0, 48'hFFFF_FFFF_FFFE, 32'h0, 1'b1)); // reply + flush
    offer(mk_send(32'h0, 16'h1234));                         // cache hit
    offer(mk_ipv4(BCAST_MAC, 16'hFFFF, 1'b1));               // delivered up
    offer(mk_ipv4(48'h1, 16'h5555, 1'b1));                   // not for us
    offer(mk_ipv4(48'h0, 16'h5555, 1'b0));                   // parse error
    // Queue full: nine more handles to a fresh IP, one is dropped.
    for (int i = 0; i < QUEUE_PER_IP + 1; i++) offer(mk_send(32'hFFFF_FFFF, 16'(i)));
    offer(mk_arp(BCAST_MAC, 2'd2, 32'hFFFF_FFFF, 48'hA5A5_5A5A_0F0F, 32'h0, 1'b1));
    // Saturate every age so that all entries expire.
    offer(mk_tick(32'hFFFF_FFFF));
    // Pending table full: nine new IPs, the ninth is dropped.
    for (int i = 0; i < PENDING_IPS + 1; i++) offer(mk_send(32'h100 + i, 16'(i)));
    offer(mk_arp(48'h0, 2'd3, 32'h100, 48'h1, 32'h0, 1'b1)); // unused opcode: flush, no reply
    go_idle();

    // Timer outlives flush: pend for 0x100 still alive with count 0; expire cache first.
    write_reg(REG_ENTRY_TTL, 48'h1);
    offer(mk_tick(32'h0));                                   // ages 0 <1: cache stays
    offer(mk_tick(32'h1));                                   // cache gone, pending at 1 < 5000
    offer(mk_send(32'h100, 16'hBEEF));                       // queues, no broadcast
    offer(mk_arp(BCAST_MAC, 2'd1, 32'h100, 48'h2, 32'h0, 1'b1));
    go_idle();

    // Cache full: seventeen bindings, the oldest is replaced.
    write_reg(REG_ENTRY_TTL, 48'hFFFF_FFFF);
    write_reg(REG_REPLY_TTL, 48'hFFFF_FFFF);
    write_reg(REG_MY_MAC, 48'hFFFF_FFFF_FFFF);
    write_reg(REG_MY_IP, 48'hFFFF_FFFF);
    for (int i = 0; i < CACHE_ENTRIES + 1; i++) begin
      offer(mk_arp(BCAST_MAC, OP_REQ, 32'h200 + i, 48'h300 + i, 32'hFFFF_FFFF, 1'b1));
      offer(mk_tick(32'd10));
    end
    for (int i = 0; i < CACHE_ENTRIES + 1; i++) offer(mk_send(32'h200 + i, 16'(i)));
    go_idle();

    // Random phases over several configurations, TTLs at their extremes among them.
    for (int ph = 0; ph < 4; ph++) begin
      host_mac = (ph == 0) ? 48'h0 : 48'({$urandom, $urandom});
      host_ip = (ph == 3) ? 32'hFFFF_FFFF : $urandom;
      write_reg(REG_MY_MAC, host_mac);
      write_reg(REG_MY_IP, {16'h0, host_ip});
      write_reg(REG_ENTRY_TTL, ph == 1 ? 48'h1 : (ph == 2 ? 48'hFFFF_FFFF : 48'd6000));
      write_reg(REG_REPLY_TTL, ph == 1 ? 48'hFFFF_FFFF : (ph == 2 ? 48'h1 : 48'd3000));
      if (ph == 1) hold_off = 1'b1;
      if (ph == 3) calm = 1'b1;
      for (int i = 0; i < 47; i++) offer(random_item());
      go_idle();
    end
    // Every input bit high once, as an ignored action.
    offer(in_item_t'('1));
    go_idle();

    $display("Covered %0d input transactions and %0d result transactions across seven setups,",
             sent_items, results_seen);
    $display("including queue and table overflow, cache replacement and TTL expiry.");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
